// File: src/vn1d_pkg.sv
// shared types, constants and arithmetic helpers for the 1d value noise sampler
package vn1d_pkg;

    localparam int LATTICE_DEPTH_DEF = 256;
    localparam int PERIOD_W          = 9;
    localparam int PERIOD_RESET      = 256;
    localparam int POS_W             = 32;
    localparam int IP_W              = 16;
    localparam int FRAC_W            = 16;
    localparam int VAL_W             = 16;
    localparam int INDEX_W           = 8;
    localparam int DIGIT_W           = 4;
    localparam int FRONT_STAGES      = IP_W / DIGIT_W;
    localparam int EASE_U_W          = FRAC_W + 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                op;
        logic [INDEX_W-1:0]  entry_index;
        logic [VAL_W-1:0]    entry_value;
        logic [PERIOD_W-1:0] rem;
        logic [FRAC_W-1:0]   ease;
    } t_front_item;

    // one radix-16 digit of a restoring remainder, rem stays below p
    function automatic logic [PERIOD_W-1:0] mod_step(
        input logic [PERIOD_W-1:0] rem,
        input logic [DIGIT_W-1:0]  bits,
        input logic [PERIOD_W-1:0] p
    );
        logic [PERIOD_W:0]   acc;
        logic [PERIOD_W-1:0] r;
        r = rem;
        for (int j = DIGIT_W - 1; j >= 0; j--) begin
            acc = {r, bits[j]};
            if (acc >= {1'b0, p}) begin
                acc = acc - {1'b0, p};
            end
            r = acc[PERIOD_W-1:0];
        end
        return r;
    endfunction

    // 3 - 2t in q2.16
    function automatic logic [EASE_U_W-1:0] ease_u(input logic [FRAC_W-1:0] t);
        return EASE_U_W'(18'h30000) - {1'b0, t, 1'b0};
    endfunction

endpackage

// File: src/vn1d_if.sv
// handshake channels of the sampler: sample items, noise results, period writes
interface vn1d_sample_if import vn1d_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [POS_W-1:0]   position;
    logic [INDEX_W-1:0] entry_index;
    logic [VAL_W-1:0]   entry_value;

    modport source(output valid, op, position, entry_index, entry_value, input ready);
    modport sink(input valid, op, position, entry_index, entry_value, output ready);
endinterface

interface vn1d_noise_if import vn1d_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] noise_value;

    modport source(output valid, noise_value, input ready);
    modport sink(input valid, noise_value, output ready);
endinterface

interface vn1d_cfg_if import vn1d_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// File: src/vn1d_front.sv
// front pipeline: lattice index remainder one digit per stage, smoothstep easing alongside
module vn1d_front import vn1d_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [FRONT_STAGES-1:0] i_ld,
    input  logic                    i_valid,
    input  logic                    i_op,
    input  logic [POS_W-1:0]        i_position,
    input  logic [INDEX_W-1:0]      i_entry_index,
    input  logic [VAL_W-1:0]        i_entry_value,
    input  logic [PERIOD_W-1:0]     i_period,
    output logic [FRONT_STAGES-1:0] o_stage_valid,
    output t_front_item             o_item
);

    logic                r_v   [FRONT_STAGES];
    logic                r_op  [FRONT_STAGES];
    logic [INDEX_W-1:0]  r_idx [FRONT_STAGES];
    logic [VAL_W-1:0]    r_val [FRONT_STAGES];
    logic [PERIOD_W-1:0] r_rem [FRONT_STAGES];
    logic [IP_W-1:0]     r_ip  [FRONT_STAGES];
    logic [FRAC_W-1:0]   r_e   [FRONT_STAGES];
    logic [FRAC_W-1:0]   r_t;

    logic                src_v   [FRONT_STAGES];
    logic                src_op  [FRONT_STAGES];
    logic [INDEX_W-1:0]  src_idx [FRONT_STAGES];
    logic [VAL_W-1:0]    src_val [FRONT_STAGES];
    logic [PERIOD_W-1:0] src_rem [FRONT_STAGES];
    logic [IP_W-1:0]     src_ip  [FRONT_STAGES];
    logic [PERIOD_W-1:0] n_rem   [FRONT_STAGES];
    logic [IP_W-1:0]     n_ip    [FRONT_STAGES];
    logic [FRAC_W-1:0]   n_e     [FRONT_STAGES];

    logic [2*FRAC_W-1:0]          t2_full;
    logic [FRAC_W+EASE_U_W-1:0]   s_full;
    logic [EASE_U_W-1:0]          s_hi;

    always_comb begin
        t2_full = (2*FRAC_W)'(i_position[FRAC_W-1:0]) * (2*FRAC_W)'(i_position[FRAC_W-1:0]);
        s_full  = (FRAC_W+EASE_U_W)'(r_e[0]) * (FRAC_W+EASE_U_W)'(ease_u(r_t));
        s_hi    = s_full[FRAC_W+EASE_U_W-1:FRAC_W];
        for (int k = 0; k < FRONT_STAGES; k++) begin
            if (k == 0) begin
                src_v[k]   = i_valid;
                src_op[k]  = i_op;
                src_idx[k] = i_entry_index;
                src_val[k] = i_entry_value;
                src_rem[k] = '0;
                src_ip[k]  = i_position[POS_W-1:FRAC_W];
            end else begin
                src_v[k]   = r_v[k-1];
                src_op[k]  = r_op[k-1];
                src_idx[k] = r_idx[k-1];
                src_val[k] = r_val[k-1];
                src_rem[k] = r_rem[k-1];
                src_ip[k]  = r_ip[k-1];
            end
            n_rem[k] = mod_step(src_rem[k], src_ip[k][IP_W-1:IP_W-DIGIT_W], i_period);
            n_ip[k]  = src_ip[k] << DIGIT_W;
        end
        n_e[0] = t2_full[2*FRAC_W-1:FRAC_W];
        n_e[1] = (|s_hi[EASE_U_W-1:FRAC_W]) ? '1 : s_hi[FRAC_W-1:0];
        for (int k = 2; k < FRONT_STAGES; k++) begin
            n_e[k] = r_e[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FRONT_STAGES; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ld[k]) begin
                r_v[k] <= src_v[k];
            end
            if (i_ld[k]) begin
                r_op[k]  <= src_op[k];
                r_idx[k] <= src_idx[k];
                r_val[k] <= src_val[k];
                r_rem[k] <= n_rem[k];
                r_ip[k]  <= n_ip[k];
                r_e[k]   <= n_e[k];
            end
        end
        if (i_ld[0]) begin
            r_t <= i_position[FRAC_W-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < FRONT_STAGES; k++) begin
            o_stage_valid[k] = r_v[k];
        end
        o_item.op          = r_op[FRONT_STAGES-1];
        o_item.entry_index = r_idx[FRONT_STAGES-1];
        o_item.entry_value = r_val[FRONT_STAGES-1];
        o_item.rem         = r_rem[FRONT_STAGES-1];
        o_item.ease        = r_e[FRONT_STAGES-1];
    end

endmodule

// File: src/vn1d_lattice.sv
// lattice memory stage: in-order entry writes and two registered neighbor reads
module vn1d_lattice import vn1d_pkg::*; #(
    parameter int LATTICE_DEPTH = LATTICE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ld,
    input  logic                i_valid,
    input  t_front_item         i_item,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_valid,
    output logic [VAL_W-1:0]    o_a,
    output logic [VAL_W-1:0]    o_b,
    output logic [FRAC_W-1:0]   o_s
);

    localparam int AW = $clog2(LATTICE_DEPTH);

    logic [VAL_W-1:0] mem [LATTICE_DEPTH];

    logic                r_v;
    logic [VAL_W-1:0]    r_a;
    logic [VAL_W-1:0]    r_b;
    logic [FRAC_W-1:0]   r_s;

    logic                is_sample;
    logic                wr_ok;
    logic [PERIOD_W-1:0] rem_next;
    logic [AW-1:0]       addr0;
    logic [AW-1:0]       addr1;
    logic [AW-1:0]       wr_addr;

    always_comb begin
        is_sample = (i_item.op == OP_SAMPLE);
        rem_next  = (i_item.rem == i_period - PERIOD_W'(1)) ? '0 : i_item.rem + PERIOD_W'(1);
        addr0     = AW'(i_item.rem);
        addr1     = AW'(rem_next);
        wr_ok     = (32'(i_item.entry_index) < 32'(LATTICE_DEPTH));
        wr_addr   = AW'(i_item.entry_index);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld && i_valid && !is_sample && wr_ok) begin
            mem[wr_addr] <= i_item.entry_value;
        end
        if (i_ld) begin
            r_a <= mem[addr0];
            r_b <= mem[addr1];
            r_s <= i_item.ease;
        end
    end

    // write beats end here, only samples go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ld) begin
            r_v <= i_valid && is_sample;
        end
    end

    assign o_valid = r_v;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_s     = r_s;

endmodule

// File: src/vn1d_blend.sv
// blend stages: eased weight times neighbor difference, then the output register
module vn1d_blend import vn1d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ld_mul,
    input  logic              i_ld_out,
    input  logic              i_valid,
    input  logic [VAL_W-1:0]  i_a,
    input  logic [VAL_W-1:0]  i_b,
    input  logic [FRAC_W-1:0] i_s,
    output logic              o_mul_valid,
    output logic              o_valid,
    output logic [VAL_W-1:0]  o_noise
);

    logic                r_mv;
    logic                r_ge;
    logic [VAL_W-1:0]    r_a;
    logic [VAL_W-1:0]    r_hi;
    logic                r_ov;
    logic [VAL_W-1:0]    r_out;

    logic                ge;
    logic [VAL_W-1:0]    diff;
    logic [2*VAL_W-1:0]  prod;
    logic [VAL_W-1:0]    n_out;

    always_comb begin
        ge    = (i_b >= i_a);
        diff  = ge ? i_b - i_a : i_a - i_b;
        prod  = (2*VAL_W)'(i_s) * (2*VAL_W)'(diff);
        n_out = r_ge ? r_a + r_hi : r_a - r_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_ld_mul) begin
                r_mv <= i_valid;
            end
            if (i_ld_out) begin
                r_ov <= r_mv;
            end
        end
        if (i_ld_mul) begin
            r_ge <= ge;
            r_a  <= i_a;
            r_hi <= prod[2*VAL_W-1:VAL_W];
        end
        if (i_ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_mul_valid = r_mv;
    assign o_valid     = r_ov;
    assign o_noise     = r_out;

endmodule

// File: src/value_noise_1d_sampler_core.sv
// top level of the 1d value noise sampler with smoothstep easing
// i_sample carries one beat per item: op 0 writes entry_value into lattice entry
// entry_index, op 1 asks for the noise at a q16.16 position. each sample beat
// gives one beat on o_noise, a write beat gives none. i_cfg writes the period,
// the wrap length of the lattice, and is always ready; write it only while idle.
// throughput is one item per cycle while the pipeline is not stalled. each
// sample goes through four remainder stages (four index bits each, smoothstep
// multiplies alongside), the lattice read, the blend multiply and the
// output add. writes land in the lattice in beat order, so a sample sees every
// write accepted before it. a stalled o_noise holds its beat while bubbles in
// the pipeline still fill; once every stage holds an item, i_sample.ready drops.
// reset empties the pipeline and sets the period to 256 (or the lattice depth
// if smaller); lattice contents are undefined until written.
module value_noise_1d_sampler_core import vn1d_pkg::*; #(
    parameter int LATTICE_DEPTH = LATTICE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vn1d_sample_if.sink   i_sample,
    vn1d_noise_if.source  o_noise,
    vn1d_cfg_if.sink      i_cfg
);

    localparam int NSTAGE     = FRONT_STAGES + 3;
    localparam int RST_PERIOD = (PERIOD_RESET > LATTICE_DEPTH) ? LATTICE_DEPTH : PERIOD_RESET;

    logic [PERIOD_W-1:0]     r_period;
    logic [PERIOD_W-1:0]     n_period;
    logic [NSTAGE-1:0]       stage_v;
    logic [NSTAGE-1:0]       ld;
    logic [FRONT_STAGES-1:0] front_v;
    t_front_item             front_item;
    logic                    lat_v;
    logic [VAL_W-1:0]        lat_a;
    logic [VAL_W-1:0]        lat_b;
    logic [FRAC_W-1:0]       lat_s;
    logic                    mul_v;
    logic                    out_v;
    logic [VAL_W-1:0]        out_noise;

    always_comb begin
        if (i_cfg.data == '0) begin
            n_period = PERIOD_W'(1);
        end else if (32'(i_cfg.data) > 32'(LATTICE_DEPTH)) begin
            n_period = PERIOD_W'(LATTICE_DEPTH);
        end else begin
            n_period = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_W'(RST_PERIOD);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_period <= n_period;
        end
    end

    assign i_cfg.ready = 1'b1;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        stage_v = {out_v, mul_v, lat_v, front_v};
        ld[NSTAGE-1] = !stage_v[NSTAGE-1] || o_noise.ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            ld[k] = !stage_v[k] || ld[k+1];
        end
    end

    assign i_sample.ready = ld[0];

    vn1d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ld          (ld[FRONT_STAGES-1:0]),
        .i_valid       (i_sample.valid),
        .i_op          (i_sample.op),
        .i_position    (i_sample.position),
        .i_entry_index (i_sample.entry_index),
        .i_entry_value (i_sample.entry_value),
        .i_period      (r_period),
        .o_stage_valid (front_v),
        .o_item        (front_item)
    );

    vn1d_lattice #(
        .LATTICE_DEPTH (LATTICE_DEPTH)
    ) u_lattice (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (ld[FRONT_STAGES]),
        .i_valid  (front_v[FRONT_STAGES-1]),
        .i_item   (front_item),
        .i_period (r_period),
        .o_valid  (lat_v),
        .o_a      (lat_a),
        .o_b      (lat_b),
        .o_s      (lat_s)
    );

    vn1d_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ld_mul    (ld[FRONT_STAGES+1]),
        .i_ld_out    (ld[FRONT_STAGES+2]),
        .i_valid     (lat_v),
        .i_a         (lat_a),
        .i_b         (lat_b),
        .i_s         (lat_s),
        .o_mul_valid (mul_v),
        .o_valid     (out_v),
        .o_noise     (out_noise)
    );

    assign o_noise.valid       = out_v;
    assign o_noise.noise_value = out_noise;

endmodule
